### hw/rtl/metric_counter_bank_with_stopwatches_defines.svh
// assertion helpers
`ifndef METRIC_COUNTER_BANK_WITH_STOPWATCHES_DEFINES_SVH
`define METRIC_COUNTER_BANK_WITH_STOPWATCHES_DEFINES_SVH

`define MCB_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

`define MCB_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

### hw/rtl/mcb_pkg.sv
package mcb_pkg;

  localparam int NUM_METRICS     = 32;
  localparam int STOPWATCH_SLOTS = 8;
  localparam int TICK_HZ         = 32768;
  localparam int MET_W           = $clog2(NUM_METRICS);
  localparam int CNT_W           = MET_W + 1;
  localparam int SLOT_W          = $clog2(STOPWATCH_SLOTS);
  localparam logic [9:0]  MS_PER_SEC = 10'd1000;
  localparam logic [28:0] DIV1000_MUL = 29'h10624DD3;
  localparam int          DIV1000_SH  = 38;

  localparam logic [2:0] ACT_CLEAR  = 3'd0;
  localparam logic [2:0] ACT_SET    = 3'd1;
  localparam logic [2:0] ACT_ADD    = 3'd2;
  localparam logic [2:0] ACT_START  = 3'd3;
  localparam logic [2:0] ACT_STOP   = 3'd4;
  localparam logic [2:0] ACT_UPDATE = 3'd5;
  localparam logic [2:0] ACT_RDALL  = 3'd6;
  localparam logic [2:0] ACT_RDONE  = 3'd7;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NOMATCH = 2'd2;
  localparam logic [1:0] ST_NOMET   = 2'd3;

  typedef enum logic [1:0] {
    ASEL_METRIC = 2'd0,
    ASEL_SLOT   = 2'd1,
    ASEL_TOP    = 2'd2
  } asel_t;

  typedef struct packed {
    logic  load;
    logic  clr;
    logic  set_wr;
    logic  start_slot;
    logic  scan_clr;
    logic  scan;
    logic  nomatch;
    logic  sidx_best;
    logic  sidx_inc;
    logic  addr_ld;
    asel_t addr_sel;
    logic  addr_dec;
    logic  e1;
    logic  e2;
    logic  e3;
    logic  rd;
    logic  add_wr;
    logic  tick_upd;
    logic  free_slot;
    logic  emit_ack;
    logic  emit_cnt;
  } cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic       found;
    logic       sidx_last;
    logic       cur_act;
    logic       n_zero;
    logic       addr_zero;
    logic       out_free;
  } sts_t;

endpackage

### hw/rtl/mcb_ctrl.sv
module mcb_ctrl import mcb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_fire,
  input  sts_t sts,
  output logic in_rdy,
  output cmd_t cmd
);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_DISP  = 13'b0000000000010,
    S_SCAN  = 13'b0000000000100,
    S_SDONE = 13'b0000000001000,
    S_SLOOP = 13'b0000000010000,
    S_E1    = 13'b0000000100000,
    S_E2    = 13'b0000001000000,
    S_E3    = 13'b0000010000000,
    S_RD    = 13'b0000100000000,
    S_WR    = 13'b0001000000000,
    S_AFTER = 13'b0010000000000,
    S_ARD   = 13'b0100000000000,
    S_AOUT  = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   resp_r, resp_nxt;

  assign in_rdy = (state_r == S_IDLE) && !resp_r;

  always_comb begin
    state_nxt = state_r;
    resp_nxt  = resp_r;
    cmd       = '0;
    if (resp_r) begin
      if (sts.out_free) begin
        cmd.emit_ack = 1'b1;
        resp_nxt     = 1'b0;
      end
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            cmd.load  = 1'b1;
            state_nxt = S_DISP;
          end
        end
        S_DISP: begin
          state_nxt = S_IDLE;
          case (sts.action)
            ACT_CLEAR: begin
              cmd.clr  = 1'b1;
              resp_nxt = 1'b1;
            end
            ACT_SET: begin
              cmd.set_wr = 1'b1;
              resp_nxt   = 1'b1;
            end
            ACT_START: begin
              cmd.start_slot = 1'b1;
              resp_nxt       = 1'b1;
            end
            ACT_STOP: begin
              cmd.scan_clr = 1'b1;
              state_nxt    = S_SCAN;
            end
            ACT_UPDATE, ACT_RDALL: begin
              cmd.scan_clr = 1'b1;
              state_nxt    = S_SLOOP;
            end
            default: begin
              cmd.addr_ld  = 1'b1;
              cmd.addr_sel = ASEL_METRIC;
              state_nxt    = S_RD;
            end
          endcase
        end
        S_SCAN: begin
          cmd.scan = 1'b1;
          if (sts.sidx_last) state_nxt = S_SDONE;
          else cmd.sidx_inc = 1'b1;
        end
        S_SDONE: begin
          if (!sts.found) begin
            cmd.nomatch = 1'b1;
            resp_nxt    = 1'b1;
            state_nxt   = S_IDLE;
          end else begin
            cmd.sidx_best = 1'b1;
            cmd.addr_ld   = 1'b1;
            cmd.addr_sel  = ASEL_METRIC;
            state_nxt     = S_E1;
          end
        end
        S_SLOOP: begin
          if (sts.cur_act) begin
            cmd.addr_ld  = 1'b1;
            cmd.addr_sel = ASEL_SLOT;
            state_nxt    = S_E1;
          end else if (sts.sidx_last) begin
            state_nxt = S_AFTER;
          end else begin
            cmd.sidx_inc = 1'b1;
          end
        end
        S_E1: begin
          cmd.e1    = 1'b1;
          state_nxt = S_E2;
        end
        S_E2: begin
          cmd.e2    = 1'b1;
          state_nxt = S_E3;
        end
        S_E3: begin
          cmd.e3    = 1'b1;
          state_nxt = S_RD;
        end
        S_RD: begin
          cmd.rd = 1'b1;
          if (sts.action == ACT_RDONE) begin
            state_nxt = S_IDLE;
            resp_nxt  = 1'b1;
          end else begin
            state_nxt = S_WR;
          end
        end
        S_WR: begin
          cmd.add_wr = 1'b1;
          if (sts.action == ACT_ADD) begin
            resp_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end else if (sts.action == ACT_STOP) begin
            cmd.free_slot = 1'b1;
            resp_nxt      = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            cmd.tick_upd = 1'b1;
            if (sts.sidx_last) begin
              state_nxt = S_AFTER;
            end else begin
              cmd.sidx_inc = 1'b1;
              state_nxt    = S_SLOOP;
            end
          end
        end
        S_AFTER: begin
          if (sts.action == ACT_UPDATE || sts.n_zero) begin
            resp_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cmd.addr_ld  = 1'b1;
            cmd.addr_sel = ASEL_TOP;
            state_nxt    = S_ARD;
          end
        end
        S_ARD: begin
          cmd.rd    = 1'b1;
          state_nxt = S_AOUT;
        end
        S_AOUT: begin
          if (sts.out_free) begin
            cmd.emit_cnt = 1'b1;
            if (sts.addr_zero) begin
              state_nxt = S_IDLE;
            end else begin
              cmd.addr_dec = 1'b1;
              state_nxt    = S_ARD;
            end
          end
        end
        default: state_nxt = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      resp_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      resp_r  <= resp_nxt;
    end
  end

endmodule

### hw/rtl/mcb_dp.sv
module mcb_dp import mcb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic [2:0]            in_action,
  input  logic [MET_W-1:0]      in_metric,
  input  logic [31:0]           in_amount,
  input  logic [31:0]           in_rate,
  input  logic [31:0]           in_now,
  input  logic                  cfg_we,
  input  logic [5:0]            cfg_val,
  input  logic                  out_rdy,
  output logic                  out_vld,
  output logic [MET_W-1:0]      out_met,
  output logic [31:0]           out_val,
  output logic [1:0]            out_st,
  output logic                  out_lst
);

  logic [5:0]       miu_r;
  logic [CNT_W-1:0] n_live;
  logic [2:0]       act_r;
  logic [MET_W-1:0] met_r;
  logic [31:0]      amt_r, rate_r, now_r;
  logic [1:0]       st_r;

  logic [31:0]      mem [NUM_METRICS];
  logic [NUM_METRICS-1:0] mval_r;
  logic [31:0]      rd_r;
  logic             rd_vld_r;
  logic [MET_W-1:0] addr_r;
  logic             addr_live;
  logic [31:0]      cnt_q;

  logic [STOPWATCH_SLOTS-1:0] sact_r;
  logic [MET_W-1:0] smet_r   [STOPWATCH_SLOTS];
  logic [31:0]      sstart_r [STOPWATCH_SLOTS];
  logic [31:0]      srate_r  [STOPWATCH_SLOTS];
  logic [7:0]       sage_r   [STOPWATCH_SLOTS];
  logic [SLOT_W-1:0] sidx_r, best_r, free_idx;
  logic [7:0]       best_age_r;
  logic             found_r, full;

  logic [31:0]      p1_r, p2_r, ms;
  logic [22:0]      el_r;
  logic [60:0]      p3;
  logic [31:0]      addend;

  logic             out_vld_r, out_lst_r;
  logic [MET_W-1:0] out_met_r;
  logic [31:0]      out_val_r;
  logic [1:0]       out_st_r;

  assign n_live    = (miu_r > 6'(NUM_METRICS)) ? CNT_W'(NUM_METRICS) : CNT_W'(miu_r);
  assign addr_live = CNT_W'(addr_r) < n_live;
  assign cnt_q     = (rd_vld_r && addr_live) ? rd_r : 32'd0;
  assign full      = &sact_r;
  assign ms        = p1_r / TICK_HZ;
  assign p3        = p2_r * DIV1000_MUL;
  assign addend    = (act_r == ACT_ADD) ? amt_r : {9'd0, el_r};

  always_comb begin
    free_idx = '0;
    for (int i = STOPWATCH_SLOTS - 1; i >= 0; i--) begin
      if (!sact_r[i]) free_idx = SLOT_W'(i);
    end
  end

  assign sts.action    = act_r;
  assign sts.found     = found_r;
  assign sts.sidx_last = (sidx_r == SLOT_W'(STOPWATCH_SLOTS - 1));
  assign sts.cur_act   = sact_r[sidx_r];
  assign sts.n_zero    = (n_live == '0);
  assign sts.addr_zero = (addr_r == '0);
  assign sts.out_free  = !out_vld_r || out_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      miu_r <= 6'd32;
    end else if (cfg_we) begin
      miu_r <= cfg_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= in_action;
      met_r  <= in_metric;
      amt_r  <= in_amount;
      rate_r <= in_rate;
      now_r  <= in_now;
      st_r   <= ST_OK;
    end else if (cmd.start_slot && full) begin
      st_r <= ST_FULL;
    end else if (cmd.nomatch) begin
      st_r <= ST_NOMATCH;
    end
    if (cmd.addr_ld) begin
      case (cmd.addr_sel)
        ASEL_METRIC: addr_r <= met_r;
        ASEL_SLOT:   addr_r <= smet_r[sidx_r];
        default:     addr_r <= MET_W'(n_live - CNT_W'(1));
      endcase
    end else if (cmd.addr_dec) begin
      addr_r <= addr_r - MET_W'(1);
    end
    if (cmd.rd) begin
      rd_r     <= mem[addr_r];
      rd_vld_r <= mval_r[addr_r];
    end
    if (cmd.set_wr && CNT_W'(met_r) < n_live) begin
      mem[met_r] <= amt_r;
    end else if (cmd.add_wr && addr_live) begin
      mem[addr_r] <= cnt_q + addend;
    end
    if (cmd.e1) p1_r <= (now_r - sstart_r[sidx_r]) * 32'(MS_PER_SEC);
    if (cmd.e2) p2_r <= srate_r[sidx_r] * ms;
    if (cmd.e3) el_r <= p3[DIV1000_SH +: 23];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mval_r <= '0;
    end else if (cmd.clr) begin
      mval_r <= '0;
    end else if (cmd.set_wr && CNT_W'(met_r) < n_live) begin
      mval_r[met_r] <= 1'b1;
    end else if (cmd.add_wr && addr_live) begin
      mval_r[addr_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_clr) begin
      sidx_r  <= '0;
      found_r <= 1'b0;
    end else if (cmd.sidx_best) begin
      sidx_r <= best_r;
    end else if (cmd.sidx_inc) begin
      sidx_r <= sidx_r + SLOT_W'(1);
    end
    if (cmd.scan && sact_r[sidx_r] && smet_r[sidx_r] == met_r &&
        (!found_r || sage_r[sidx_r] < best_age_r)) begin
      found_r    <= 1'b1;
      best_r     <= sidx_r;
      best_age_r <= sage_r[sidx_r];
    end
    if (cmd.tick_upd) sstart_r[sidx_r] <= now_r;
    for (int i = 0; i < STOPWATCH_SLOTS; i++) begin
      if (cmd.start_slot && !full) begin
        if (SLOT_W'(i) == free_idx) begin
          smet_r[i]   <= met_r;
          sstart_r[i] <= now_r;
          srate_r[i]  <= rate_r;
          sage_r[i]   <= 8'd0;
        end else if (sact_r[i]) begin
          sage_r[i] <= sage_r[i] + 8'd1;
        end
      end
      if (cmd.free_slot && sact_r[i] && sage_r[i] > best_age_r) begin
        sage_r[i] <= sage_r[i] - 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sact_r <= '0;
    end else if (cmd.start_slot && !full) begin
      sact_r[free_idx] <= 1'b1;
    end else if (cmd.free_slot) begin
      sact_r[sidx_r] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.emit_ack || cmd.emit_cnt) begin
      out_vld_r <= 1'b1;
    end else if (out_rdy) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_cnt) begin
      out_met_r <= addr_r;
      out_val_r <= cnt_q;
      out_st_r  <= ST_OK;
      out_lst_r <= (addr_r == '0);
    end else if (cmd.emit_ack) begin
      out_lst_r <= 1'b1;
      out_val_r <= (act_r == ACT_RDONE) ? cnt_q : 32'd0;
      if (act_r == ACT_CLEAR || act_r == ACT_UPDATE || act_r == ACT_RDALL) begin
        out_met_r <= '0;
      end else begin
        out_met_r <= met_r;
      end
      out_st_r <= (act_r == ACT_RDALL) ? ST_NOMET : st_r;
    end
  end

  assign out_vld = out_vld_r;
  assign out_met = out_met_r;
  assign out_val = out_val_r;
  assign out_st  = out_st_r;
  assign out_lst = out_lst_r;

endmodule

### hw/rtl/metric_counter_bank_with_stopwatches.sv
// Bank of 32 counters plus 8 stopwatches. One item is taken at a time; a result waits in the
// output register while the next item is accepted. A stop scans the 8 slots, then on a match
// runs a 3-stage multiply chain and a counter read-modify-write; update walks every slot and
// runs the same chain and write for each active one; read all walks the slots likewise and
// then reads out the live counters one at a time from the top down. The slot walk and the
// single counter memory port set how long these actions take.
`include "metric_counter_bank_with_stopwatches_defines.svh"

module metric_counter_bank_with_stopwatches import mcb_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,   // metric, amount, rate, now_ticks, zero pad
  input  logic [2:0]   in_tuser,   // action
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [39:0]  out_tdata,  // out_metric, out_value, zero pad
  output logic [1:0]   out_tuser,  // status
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [5:0]   cfg_data
);

  cmd_t             cmd;
  sts_t             sts;
  logic             in_fire;
  logic [MET_W-1:0] o_met;
  logic [31:0]      o_val;

  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_tdata = {3'd0, o_val, o_met};

  mcb_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .sts     (sts),
    .in_rdy  (in_tready),
    .cmd     (cmd)
  );

  mcb_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_action (in_tuser),
    .in_metric (in_tdata[4:0]),
    .in_amount (in_tdata[36:5]),
    .in_rate   (in_tdata[68:37]),
    .in_now    (in_tdata[100:69]),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_val   (cfg_data),
    .out_rdy   (out_tready),
    .out_vld   (out_tvalid),
    .out_met   (o_met),
    .out_val   (o_val),
    .out_st    (out_tuser),
    .out_lst   (out_tlast)
  );

  `MCB_ASSERT_NEXT(a_one_item, in_tvalid && in_tready, !in_tready)
  `MCB_ASSERT_NOW(a_nomet_last, out_tvalid && out_tuser == ST_NOMET, out_tlast)
  `MCB_ASSERT_NOW(a_err_zero, out_tvalid && out_tuser != ST_OK, out_tdata[36:5] == 32'd0)

endmodule
